// ===== rtl/crcook_pkg.sv =====
// ----------------------------------------------------------------------------
// crcook_pkg
// Types, register indexes and constants shared by the counter rate cooker.
// ----------------------------------------------------------------------------
package crcook_pkg;

   // counter readings wrap at 2^COUNTER_WRAP_BITS (8 to 48)
   localparam int COUNTER_WRAP_BITS = 48;

   localparam int TIME_W   = 40;
   localparam int VALUE_W  = 48;
   localparam int FACTOR_W = 32;
   localparam int DIFF_W   = VALUE_W + 2;
   localparam int PROD_W   = VALUE_W + FACTOR_W;
   localparam int QUOT_W   = 64;
   localparam int STEP_W   = $clog2(QUOT_W);
   localparam int CSR_IDX_W = 2;

   localparam logic [DIFF_W-1:0] WRAP_ADD = DIFF_W'(1) << COUNTER_WRAP_BITS;
   localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [QUOT_W-1:0] LIM_POS = QUOT_W'(VAL_MAX);
   localparam logic [QUOT_W-1:0] LIM_NEG = QUOT_W'(VAL_MAX) + QUOT_W'(1);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_W - 1);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COOK_ENABLE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNTER_MODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_FACTOR  = 2'd2;

   typedef struct packed {
      logic [TIME_W-1:0]         sample_time;
      logic signed [VALUE_W-1:0] sample_value;
   } req_payload_type;

   typedef struct packed {
      logic [TIME_W-1:0]         out_time;
      logic signed [VALUE_W-1:0] out_value;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_RATE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_CHECK,
      ST_DIV,
      ST_SCALE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_in;
      logic diff;
      logic stamp;
      logic mul_lo;
      logic mul_hi;
      logic div_init;
      logic div_step;
      logic finish;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic cook_en;
      logic cnt_mode;
      logic rate_on;
      logic time_zero;
      logic stamp_zero;
      logic scale_ok;
      logic ovf;
      logic div_last;
      logic out_free;
   } stat_type;

endpackage

// ===== rtl/counter_rate_cooker_unit.sv =====
// ----------------------------------------------------------------------------
// counter_rate_cooker_unit
// Converts timestamped samples: pass-through, counter differences and scaled rates.
// ----------------------------------------------------------------------------
// The req channel takes one sample transaction (time, Q32.16 value) at a
// time; the rsp channel returns zero or one result per sample. Both use
// valid/ready. The csr port writes cook_enable, counter_mode and rate_factor
// by index; write only while no transaction is in flight.
// Pass-through results go through IDLE, DIFF and EMIT; other unscaled
// results also pass RATE. A rate-scaled result takes two multiply steps
// on the shared 32x32 multiplier, then a 64-step restoring divider,
// one quotient bit per cycle, sets the figure; a product too large for any
// quotient skips the divider and saturates. Dropped samples free the input
// from DIFF or RATE. One sample is worked on at a time; the next is taken
// the cycle after the result is loaded.
// The result sits in an output register; a stalled receiver holds it there
// while the next sample is already accepted and processed, and the block
// waits only when a second result is ready before the first is taken.
// Reset clears configuration, the previous counter reading and the
// previous time stamp, and empties the output register.
// ----------------------------------------------------------------------------
module counter_rate_cooker_unit
   import crcook_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FACTOR_W-1:0]  csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_payload_type      rsp_payload
);

   cmd_type  cmd;
   stat_type stat;

   crcook_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   crcook_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

// ===== rtl/crcook_ctrl.sv =====
// ----------------------------------------------------------------------------
// crcook_ctrl
// Sequencer: walks one transaction through diff, rate setup, multiply,
// divide and emit, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module crcook_ctrl
   import crcook_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DIFF;
         end
         ST_DIFF: begin
            if (!stat.cook_en) state_in = ST_EMIT;
            else if (stat.time_zero) state_in = ST_IDLE;
            else state_in = ST_RATE;
         end
         ST_RATE: begin
            if (!stat.rate_on) state_in = ST_EMIT;
            else if (stat.stamp_zero) state_in = ST_IDLE;
            else if (stat.scale_ok) state_in = ST_MUL_LO;
            else state_in = ST_EMIT;
         end
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_CHECK;
         ST_CHECK: begin
            state_in = stat.ovf ? ST_SCALE : ST_DIV;
         end
         ST_DIV: begin
            if (stat.div_last) state_in = ST_SCALE;
         end
         ST_SCALE: state_in = ST_EMIT;
         ST_EMIT: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load_in = req_valid;
         end
         ST_DIFF: begin
            cmd.diff = stat.cook_en && !stat.time_zero && stat.cnt_mode;
         end
         ST_RATE: begin
            cmd.stamp = stat.rate_on;
         end
         ST_MUL_LO: cmd.mul_lo = 1'b1;
         ST_MUL_HI: cmd.mul_hi = 1'b1;
         ST_CHECK:  cmd.div_init = 1'b1;
         ST_DIV:    cmd.div_step = 1'b1;
         ST_SCALE:  cmd.finish = 1'b1;
         ST_EMIT:   cmd.load_out = stat.out_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== rtl/crcook_dp.sv =====
// ----------------------------------------------------------------------------
// crcook_dp
// Datapath: configuration registers, counter difference, shared 32x32
// multiplier, radix-2 restoring divider and the output register.
// ----------------------------------------------------------------------------
module crcook_dp
   import crcook_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FACTOR_W-1:0]  csr_wr_data,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  cmd_type              cmd,
   output stat_type             stat
);

   // configuration
   logic                cook_ff;
   logic                cmode_ff;
   logic [FACTOR_W-1:0] factor_ff;

   // state carried between transactions
   logic [VALUE_W-1:0] prev_reading_ff, prev_reading_in;
   logic [TIME_W-1:0]  prev_stamp_ff, prev_stamp_in;

   // working registers
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic               inv_ff, inv_in;
   logic               neg_ff, neg_in;
   logic               ovf_ff, ovf_in;
   logic [TIME_W-1:0]  delta_ff, delta_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [TIME_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   logic [DIFF_W-1:0]   diff;
   logic [VALUE_W-1:0]  diff_val;
   logic [VALUE_W-1:0]  mag;
   logic [FACTOR_W-1:0] mul_a;
   logic [2*FACTOR_W-1:0] mul_p;
   logic [TIME_W:0]     shifted;
   logic                fits;
   logic                ovf_now;
   logic [QUOT_W-1:0]   lim;
   logic [QUOT_W-1:0]   qsat;
   logic [VALUE_W-1:0]  scaled;

   always_ff @(posedge clock) begin
      if (reset) begin
         cook_ff  <= 1'b0;
         cmode_ff <= 1'b0;
         factor_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_COOK_ENABLE:  cook_ff   <= csr_wr_data[0];
            CSR_COUNTER_MODE: cmode_ff  <= csr_wr_data[0];
            CSR_RATE_FACTOR:  factor_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // counter difference with wrap, clamp positive overflow
   always_comb begin
      if ($signed(val_ff) >= $signed(prev_reading_ff)) begin
         diff = DIFF_W'($signed(val_ff)) - DIFF_W'($signed(prev_reading_ff));
      end else begin
         diff = DIFF_W'($signed(val_ff)) - DIFF_W'($signed(prev_reading_ff)) + WRAP_ADD;
      end
      if (diff[DIFF_W-2:VALUE_W-1] != '0) diff_val = VAL_MAX;
      else diff_val = diff[VALUE_W-1:0];
   end

   assign mag   = val_ff[VALUE_W-1] ? (~val_ff + VALUE_W'(1)) : val_ff;
   assign mul_a = cmd.mul_hi ? FACTOR_W'(mag[VALUE_W-1:FACTOR_W]) : mag[FACTOR_W-1:0];
   assign mul_p = (2*FACTOR_W)'(mul_a) * (2*FACTOR_W)'(factor_ff);

   assign ovf_now = TIME_W'(prod_ff[PROD_W-1:QUOT_W]) >= delta_ff;
   assign shifted = {rem_ff, prod_ff[QUOT_W-1]};
   assign fits    = shifted >= {1'b0, delta_ff};

   assign lim    = neg_ff ? LIM_NEG : LIM_POS;
   assign qsat   = (ovf_ff || prod_ff[QUOT_W-1:0] > lim) ? lim : prod_ff[QUOT_W-1:0];
   assign scaled = neg_ff ? (~qsat[VALUE_W-1:0] + VALUE_W'(1)) : qsat[VALUE_W-1:0];

   always_comb begin
      time_in         = time_ff;
      val_in          = val_ff;
      inv_in          = inv_ff;
      neg_in          = neg_ff;
      ovf_in          = ovf_ff;
      delta_in        = delta_ff;
      prod_in         = prod_ff;
      rem_in          = rem_ff;
      cnt_in          = cnt_ff;
      prev_reading_in = prev_reading_ff;
      prev_stamp_in   = prev_stamp_ff;
      if (cmd.load_in) begin
         time_in = req_payload.sample_time;
         val_in  = req_payload.sample_value;
         inv_in  = 1'b0;
      end
      if (cmd.diff) begin
         prev_reading_in = val_ff;
         inv_in = diff[DIFF_W-1];
         val_in = diff_val;
      end
      if (cmd.stamp) begin
         prev_stamp_in = time_ff;
         delta_in = time_ff - prev_stamp_ff;
      end
      if (cmd.mul_lo) begin
         neg_in  = val_ff[VALUE_W-1];
         prod_in = PROD_W'(mul_p);
      end
      if (cmd.mul_hi) begin
         prod_in = prod_ff + {mul_p[VALUE_W-1:0], {FACTOR_W{1'b0}}};
      end
      if (cmd.div_init) begin
         ovf_in = ovf_now;
         rem_in = TIME_W'(prod_ff[PROD_W-1:QUOT_W]);
         cnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in  = fits ? TIME_W'(shifted - {1'b0, delta_ff}) : shifted[TIME_W-1:0];
         prod_in = {prod_ff[PROD_W-1:QUOT_W], prod_ff[QUOT_W-2:0], fits};
         cnt_in  = cnt_ff + STEP_W'(1);
      end
      if (cmd.finish) begin
         val_in = scaled;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_reading_ff <= '0;
         prev_stamp_ff   <= '0;
      end else begin
         prev_reading_ff <= prev_reading_in;
         prev_stamp_ff   <= prev_stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      time_ff  <= time_in;
      val_ff   <= val_in;
      inv_ff   <= inv_in;
      neg_ff   <= neg_in;
      ovf_ff   <= ovf_in;
      delta_ff <= delta_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
   end

   // output register: hold until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.load_out) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.out_time  = time_ff;
         rsp_data_in.out_value = inv_ff ? VAL_MAX : val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   assign stat.cook_en    = cook_ff;
   assign stat.cnt_mode   = cmode_ff;
   assign stat.rate_on    = factor_ff != '0;
   assign stat.time_zero  = time_ff == '0;
   assign stat.stamp_zero = prev_stamp_ff == '0;
   assign stat.scale_ok   = (time_ff > prev_stamp_ff) && !inv_ff;
   assign stat.ovf        = ovf_now;
   assign stat.div_last   = cnt_ff == LAST_STEP;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

// ===== test/tb_counter_rate_cooker_unit.sv =====
// ----------------------------------------------------------------------------
// tb_counter_rate_cooker_unit
// Self-checking bench for the counter rate cooker. A driver and a monitor
// run on the clock. Each accepted sample goes through a cycle-free
// predictor of pass-through, counter differences with wrap, and rate
// scaling. Each result transaction is checked against the oldest expected
// result. Phases vary the configuration, the idle rates of the sender and
// the receiver, and the hold-off pressure on the receiver.
// ----------------------------------------------------------------------------
module tb_counter_rate_cooker_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import crcook_pkg::*;

   localparam int CLK_PERIOD  = 4;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_WAIT  = 100;
   localparam longint SAMPLE_MAX_L = (longint'(1) <<< (VALUE_W - 1)) - 1;
   localparam logic [VALUE_W-1:0] SAMPLE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic [TIME_W-1:0]  TIME_MAX   = {TIME_W{1'b1}};

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_COOK_ENABLE;
   logic [FACTOR_W-1:0]  csr_wr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_payload_type      req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_payload_type      rsp_payload;

   // predictor copy of configuration and state
   bit                   cfg_cook;
   bit                   cfg_counter;
   logic [FACTOR_W-1:0]  cfg_factor;
   longint               last_reading;
   logic [TIME_W-1:0]    last_stamp;

   req_payload_type      sample_queue[$];
   rsp_payload_type      cooked_queue[$];

   int                   send_idle_pct;
   int                   recv_stall_pct;
   bit                   rsp_hold = 1'b0;
   bit                   req_taken = 1'b0;
   int                   mismatch_count = 0;
   int                   cycle_count = 0;

   logic [TIME_W-1:0]    gen_time;
   logic [VALUE_W-1:0]   gen_reading;

   counter_rate_cooker_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // trunc(factor * value / dt), saturated to the signed output range
   function automatic logic signed [VALUE_W-1:0] scale_to_rate(input longint v,
         input logic [FACTOR_W-1:0] f, input logic [TIME_W-1:0] dt);
      logic [VALUE_W-1:0] mag;
      logic [79:0]        prod;
      logic [79:0]        quo;
      logic [79:0]        lim;
      mag  = (v < 0) ? VALUE_W'(-v) : VALUE_W'(v);
      prod = 80'(mag) * 80'(f);
      quo  = prod / 80'(dt);
      lim  = (v < 0) ? (80'(1) << (VALUE_W - 1)) : 80'(SAMPLE_MAX_L);
      if (quo > lim) quo = lim;
      return (v < 0) ? VALUE_W'(80'(0) - quo) : VALUE_W'(quo);
   endfunction

   // returns 1 when the sample yields a result
   function automatic bit cook_sample(input req_payload_type s, output rsp_payload_type r);
      logic [TIME_W-1:0] t;
      longint            v;
      longint            nv;
      longint            dlt;
      bit                ok;
      t  = s.sample_time;
      v  = longint'($signed(s.sample_value));
      ok = 1'b1;
      r.out_time  = t;
      r.out_value = s.sample_value;
      if (!cfg_cook) return 1'b1;
      if (t == '0) return 1'b0;
      if (cfg_counter) begin
         nv = v;
         if (nv >= last_reading) dlt = nv - last_reading;
         else dlt = (longint'(1) <<< COUNTER_WRAP_BITS) - last_reading + nv;
         if (dlt < 0) ok = 1'b0;
         else if (dlt > SAMPLE_MAX_L) dlt = SAMPLE_MAX_L;
         v = dlt;
         last_reading = nv;
      end
      if (cfg_factor != '0) begin
         // first kept sample only records its time
         if (last_stamp == '0) begin
            last_stamp = t;
            return 1'b0;
         end
         if (t > last_stamp && ok) v = longint'(scale_to_rate(v, cfg_factor, t - last_stamp));
         last_stamp = t;
      end
      r.out_value = ok ? VALUE_W'(v) : VAL_MAX;
      return 1'b1;
   endfunction

   // driver: advance to the next sample once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= sample_queue.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: predict on accepted samples, check result transactions
   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready && cook_sample(req_payload, want))
            cooked_queue.push_back(want);
         if (rsp_valid && rsp_ready) begin
            if (cooked_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count < 50)
                  $error("unexpected result transaction: out_time %0h out_value %0h",
                         rsp_payload.out_time, rsp_payload.out_value);
            end else begin
               want = cooked_queue.pop_front();
               if (rsp_payload.out_time !== want.out_time) begin
                  mismatch_count++;
                  if (mismatch_count < 50)
                     $error("out_time: expected %0h, actual %0h",
                            want.out_time, rsp_payload.out_time);
               end
               if (rsp_payload.out_value !== want.out_value) begin
                  mismatch_count++;
                  if (mismatch_count < 50)
                     $error("out_value: expected %0d, actual %0d",
                            want.out_value, rsp_payload.out_value);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL counter_rate_cooker_unit");
         $finish;
      end
   end

   // wait until nothing is queued, offered or expected, then let the block go quiet
   task automatic settle();
      do @(posedge clock);
      while (sample_queue.size() != 0 || req_valid || cooked_queue.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic set_mode(input bit cook, input bit cnt, input logic [FACTOR_W-1:0] factor,
         input int send_idle, input int recv_stall);
      settle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_COOK_ENABLE;
      csr_wr_data <= FACTOR_W'(cook);
      @(negedge clock);
      csr_index   <= CSR_COUNTER_MODE;
      csr_wr_data <= FACTOR_W'(cnt);
      @(negedge clock);
      csr_index   <= CSR_RATE_FACTOR;
      csr_wr_data <= factor;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cfg_cook    = cook;
      cfg_counter = cnt;
      cfg_factor  = factor;
      @(posedge clock);
      send_idle_pct  = send_idle;
      recv_stall_pct = recv_stall;
   endtask

   task automatic push_sample(input logic [TIME_W-1:0] t, input logic [VALUE_W-1:0] v);
      req_payload_type s;
      s.sample_time  = t;
      s.sample_value = v;
      sample_queue.push_back(s);
   endtask

   // mostly rising time stamps and climbing readings, with jumps, repeats and zero times
   task automatic push_random(input bit readings);
      int                 pick;
      logic [TIME_W-1:0]  t;
      logic [VALUE_W-1:0] v;
      pick = $urandom_range(99);
      if (pick < 5) begin
         t = '0;
      end else if (pick < 12) begin
         t = {8'($urandom_range(255)), 32'($urandom)};
         gen_time = t;
      end else if (pick < 17) begin
         t = gen_time;
      end else begin
         gen_time = gen_time + TIME_W'($urandom_range(1, (pick < 70) ? 10 : 100000));
         t = gen_time;
      end
      pick = $urandom_range(99);
      if (readings && pick < 70) begin
         gen_reading = gen_reading + ((pick < 60) ? VALUE_W'($urandom_range(0, 1 << 20))
                                                  : {16'($urandom), 32'($urandom)});
         v = gen_reading;
      end else if (pick < 80) begin
         v = {16'($urandom), 32'($urandom)};
      end else if (pick < 88) begin
         case ($urandom_range(3))
            0: v = VAL_MAX;
            1: v = SAMPLE_MIN;
            2: v = '0;
            default: v = '1;
         endcase
      end else begin
         v = VALUE_W'(longint'($urandom_range(0, 2000000)) - 1000000);
      end
      push_sample(t, v);
   endtask

   task automatic run_random(input int n, input bit cook, input bit cnt,
         input logic [FACTOR_W-1:0] factor, input int send_idle, input int recv_stall);
      set_mode(cook, cnt, factor, send_idle, recv_stall);
      repeat (n) push_random(cnt);
   endtask

   initial begin
      cfg_cook       = 1'b0;
      cfg_counter    = 1'b0;
      cfg_factor     = '0;
      last_reading   = 0;
      last_stamp     = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      gen_time       = 40'd1000;
      gen_reading    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // pass-through, time zero included
      set_mode(1'b0, 1'b0, '0, 0, 0);
      push_sample('0, SAMPLE_MIN);
      push_sample(TIME_MAX, VAL_MAX);
      push_sample(40'd1, '1);

      // cooking on, plain values: zero time dropped
      set_mode(1'b1, 1'b0, '0, 0, 0);
      push_sample('0, 48'd123);
      push_sample(40'd7, VAL_MAX);
      push_sample(40'd8, SAMPLE_MIN);

      // counter differences: wrap, overflow saturation
      set_mode(1'b1, 1'b1, '0, 0, 0);
      push_sample(40'd10, 48'd5);
      push_sample(40'd11, 48'd3);
      push_sample(40'd12, VAL_MAX);
      push_sample(40'd13, SAMPLE_MIN);
      push_sample(40'd14, VAL_MAX);

      // rate scaling: first stamp, zero and negative dt, saturation both ways
      set_mode(1'b1, 1'b0, '1, 0, 0);
      push_sample(40'd100, 48'd1);
      push_sample(40'd100, 48'd9);
      push_sample(40'd50, 48'd9);
      push_sample(40'd51, VAL_MAX);
      push_sample(40'd52, SAMPLE_MIN);

      // truncation toward zero
      set_mode(1'b1, 1'b0, 32'd3, 0, 0);
      push_sample(40'd54, -48'sd5);
      push_sample(40'd55, '0);

      // counter and rate together
      set_mode(1'b1, 1'b1, 32'd1, 0, 0);
      push_sample(40'd60, VAL_MAX);
      push_sample(40'd70, SAMPLE_MIN);

      run_random(150, 1'b0, 1'b0, '0, 0, 0);
      run_random(150, 1'b1, 1'b0, '0, 50, 0);
      run_random(150, 1'b1, 1'b1, '0, 0, 50);
      run_random(250, 1'b1, 1'b0, $urandom, 24, 24);
      run_random(250, 1'b1, 1'b1, FACTOR_W'($urandom_range(1, 4000)), 0, 0);
      run_random(150, 1'b1, 1'b1, '1, 50, 0);
      run_random(150, 1'b1, 1'b0, 32'd1, 0, 50);
      run_random(100, 1'b0, 1'b1, $urandom, 24, 24);

      // hold the receiver off while samples keep coming so the input stalls
      set_mode(1'b0, 1'b0, '0, 0, 0);
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      @(posedge clock);
      repeat (40) push_random(1'b0);

      settle();
      if (mismatch_count == 0) $display("PASS counter_rate_cooker_unit");
      else $display("FAIL counter_rate_cooker_unit");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/crcook_pkg.sv
rtl/crcook_ctrl.sv
rtl/crcook_dp.sv
rtl/counter_rate_cooker_unit.sv
test/tb_counter_rate_cooker_unit.sv
